[src/assert_macros.svh]
// Assertion macros used by the port-level checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that stays live through reset.
`define ASSERT_NEXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset-time check failed");

`endif

[src/u8d_pkg.sv]
// Types, constants and the overlong-limit table of the UTF-8 stream decoder.
// Depends on nothing; used by the decode step and the top level.
package u8d_pkg;

    localparam int CP_W    = 31;
    localparam int CNT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int CONT_W  = 6;

    typedef struct packed {
        logic [CP_W-1:0]  partial_value;
        logic [CNT_W-1:0] bytes_pending;
        logic [CNT_W-1:0] length_class;
    } t_state;

    typedef struct packed {
        logic            has_result;
        logic [CP_W-1:0] code_point;
        logic            decode_error;
    } t_result;

    localparam t_state STATE_IDLE = '{default: '0};

    // Largest value that is still overlong for a given continuation count.
    function automatic logic [CP_W-1:0] overlong_limit(input logic [CNT_W-1:0] length_class);
        logic [CP_W-1:0] v;
        begin
            unique case (length_class)
                3'd1:    v = CP_W'(32'h0000_007F);
                3'd2:    v = CP_W'(32'h0000_07FF);
                3'd3:    v = CP_W'(32'h0000_FFFF);
                3'd4:    v = CP_W'(32'h001F_FFFF);
                3'd5:    v = CP_W'(32'h03FF_FFFF);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[src/u8d_stream_if.sv]
// Valid/ready channel interfaces for the byte input and the code point output.
// Depends on nothing.
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_mark;

    modport source (output valid, output data_byte, output end_mark, input ready);
    modport sink   (input valid, input data_byte, input end_mark, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic        decode_error;

    modport source (output valid, output code_point, output decode_error, input ready);
    modport sink   (input valid, input code_point, input decode_error, output ready);
endinterface

[src/u8d_decode.sv]
// One decode step: next state and optional result from the state and one byte.
// Depends on u8d_pkg.
module u8d_decode (
    input  u8d_pkg::t_state          i_state,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_end_mark,
    output u8d_pkg::t_state          o_next_state,
    output u8d_pkg::t_result         o_result
);
    import u8d_pkg::*;

    logic [CP_W-1:0]  w_shifted;
    logic [CNT_W-1:0] w_pending_dec;

    assign w_shifted     = {i_state.partial_value[CP_W-CONT_W-1:0], i_data_byte[CONT_W-1:0]};
    assign w_pending_dec = i_state.bytes_pending - CNT_W'(1);

    always_comb begin
        o_next_state = i_state;
        o_result     = '{has_result: 1'b0, code_point: '0, decode_error: 1'b0};

        if (i_end_mark) begin
            // truncated sequence; end mark while idle changes nothing
            if (i_state.bytes_pending != '0) begin
                o_next_state = STATE_IDLE;
                o_result     = '{has_result: 1'b1, code_point: '0, decode_error: 1'b1};
            end
        end else if (i_state.bytes_pending == '0) begin
            unique casez (i_data_byte)
                8'b0???????: begin
                    o_result = '{has_result: 1'b1,
                                 code_point: CP_W'(i_data_byte),
                                 decode_error: 1'b0};
                end
                8'b110?????: o_next_state = '{CP_W'(i_data_byte[4:0]), 3'd1, 3'd1};
                8'b1110????: o_next_state = '{CP_W'(i_data_byte[3:0]), 3'd2, 3'd2};
                8'b11110???: o_next_state = '{CP_W'(i_data_byte[2:0]), 3'd3, 3'd3};
                8'b111110??: o_next_state = '{CP_W'(i_data_byte[1:0]), 3'd4, 3'd4};
                8'b1111110?: o_next_state = '{CP_W'(i_data_byte[0]),   3'd5, 3'd5};
                default: begin
                    // stray continuation, 0xFE or 0xFF
                    o_next_state = STATE_IDLE;
                    o_result     = '{has_result: 1'b1, code_point: '0, decode_error: 1'b1};
                end
            endcase
        end else if (i_data_byte[7:6] != 2'b10) begin
            o_next_state = STATE_IDLE;
            o_result     = '{has_result: 1'b1, code_point: '0, decode_error: 1'b1};
        end else if (w_pending_dec != '0) begin
            o_next_state.partial_value = w_shifted;
            o_next_state.bytes_pending = w_pending_dec;
        end else begin
            o_next_state = STATE_IDLE;
            if (w_shifted > overlong_limit(i_state.length_class)) begin
                o_result = '{has_result: 1'b1, code_point: w_shifted, decode_error: 1'b0};
            end else begin
                o_result = '{has_result: 1'b1, code_point: '0, decode_error: 1'b1};
            end
        end
    end

endmodule

[src/utf8_stream_decoder_top.sv]
// UTF-8 stream decoder (31-bit code points, one to six byte sequences).
// Byte input channel i_in (data_byte, end_mark), result channel o_out
// (code_point, decode_error), both valid/ready; a transaction moves on
// a clock edge with valid and ready high.
// Each byte transaction lands in an input register; the decode step then
// updates the sequence state and, when a character completes or an error
// is found, loads the result register. Throughput: one byte per cycle
// while no result-producing byte waits behind a stalled result; each
// continuation byte shifts six bits into the sequence state.
// Bytes that give no result never wait on the output side.
// When o_out is stalled the result register holds its transaction and one
// more byte may sit in the input register; i_in.ready drops only while a
// result-producing byte waits behind a stalled result.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to idle with no partial character.
// Depends on u8d_pkg, u8d_stream_if and u8d_decode.
module utf8_stream_decoder_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out
);
    import u8d_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;
    t_state            r_state;
    t_state            n_state;
    t_result           w_result;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_err;
    logic              w_out_free;
    logic              w_advance;

    u8d_decode u_decode (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_end_mark   (r_in_end),
        .o_next_state (n_state),
        .o_result     (w_result)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_advance  = r_in_valid && (w_out_free || !w_result.has_result);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.end_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_IDLE;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_result.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_result.has_result) begin
            r_out_cp  <= w_result.code_point;
            r_out_err <= w_result.decode_error;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.code_point   = r_out_cp;
    assign o_out.decode_error = r_out_err;

endmodule

[src/u8d_checker.sv]
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on assert_macros.svh and utf8_stream_decoder_top.
`include "assert_macros.svh"

module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [30:0] i_out_code_point,
    input logic        i_out_decode_error
);

    // a stalled result transaction keeps its valid and its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_code_point) && $stable(i_out_decode_error))

    // error results never carry a code point
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_decode_error, i_out_code_point == '0)

    // with the result register empty there is always room for a byte
    `ASSERT_IMPLY(a_ready_free, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // reset leaves nothing to deliver
    `ASSERT_NEXT_NR(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_code_point   (o_out.code_point),
    .i_out_decode_error (o_out.decode_error)
);

[dv/utf8_stream_decoder_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder_top: byte transactions in, code points out.
// Depends on u8d_pkg, u8d_stream_if and the decoder RTL.
module utf8_stream_decoder_top_tb;
    import u8d_pkg::*;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_OFF_LEN   = 200;
    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            decode_error;
    } t_char_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8d_in_if  in_ch ();
    u8d_out_if out_ch ();

    utf8_stream_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Decoder state as seen by the predictor
    logic [CP_W-1:0]  seq_value;
    logic [CNT_W-1:0] seq_left;
    logic [CNT_W-1:0] seq_class;

    t_char_result expected_chars[$];
    t_char_result got_char;
    t_char_result want_char;

    int fail_cnt      = 0;
    int checked_cnt   = 0;
    int byte_cnt      = 0;
    int char_cnt      = 0;
    int err_cnt       = 0;
    int counted_items = 0;
    int idle_cycles   = 0;

    int burst_left    = 0;
    bit steady_sender = 1'b0;
    int hold_request  = 0;

    function automatic logic [CP_W-1:0] overlong_bound(input logic [CNT_W-1:0] n_cont);
        case (n_cont)
            3'd1:    return 31'h0000007F;
            3'd2:    return 31'h000007FF;
            3'd3:    return 31'h0000FFFF;
            3'd4:    return 31'h001FFFFF;
            3'd5:    return 31'h03FFFFFF;
            default: return '0;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] low_ones(input int nbits);
        return (31'h1 << nbits) - 31'h1;
    endfunction

    // Payload bits carried by a sequence of n bytes
    function automatic int seq_bits(input int n);
        return (n == 1) ? 7 : 5 * n + 1;
    endfunction

    function automatic logic [7:0] lead_prefix(input int n);
        case (n)
            2:       return 8'hC0;
            3:       return 8'hE0;
            4:       return 8'hF0;
            5:       return 8'hF8;
            default: return 8'hFC;
        endcase
    endfunction

    task automatic open_seq(input logic [CP_W-1:0] payload, input logic [CNT_W-1:0] n_cont);
        seq_value = payload;
        seq_left  = n_cont;
        seq_class = n_cont;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic e);
        t_char_result r;
        logic [CP_W-1:0] v;
        bit emit;
        r = '0;
        emit = 1'b0;
        if (e) begin
            if (seq_left != 0) begin
                emit = 1'b1;
                r.decode_error = 1'b1;
            end
        end else if (seq_left == 0) begin
            casez (b)
                8'b0???????: begin
                    emit = 1'b1;
                    r.code_point = CP_W'(b);
                end
                8'b110?????: open_seq(CP_W'(b[4:0]), 3'd1);
                8'b1110????: open_seq(CP_W'(b[3:0]), 3'd2);
                8'b11110???: open_seq(CP_W'(b[2:0]), 3'd3);
                8'b111110??: open_seq(CP_W'(b[1:0]), 3'd4);
                8'b1111110?: open_seq(CP_W'(b[0]), 3'd5);
                default: begin
                    emit = 1'b1;
                    r.decode_error = 1'b1;
                end
            endcase
        end else if (b[7:6] != CONT_TAG) begin
            emit = 1'b1;
            r.decode_error = 1'b1;
        end else begin
            v = {seq_value[CP_W-7:0], b[5:0]};
            seq_left = seq_left - 3'd1;
            seq_value = v;
            if (seq_left == 0) begin
                emit = 1'b1;
                if (v > overlong_bound(seq_class))
                    r.code_point = v;
                else
                    r.decode_error = 1'b1;
            end
        end
        if (emit) begin
            // any result, good or bad, leaves the decoder idle
            open_seq('0, 3'd0);
            expected_chars.push_back(r);
            if (r.decode_error)
                err_cnt++;
            else
                char_cnt++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left == 0) begin
            gap = (steady_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                in_ch.valid     <= 1'b0;
                in_ch.data_byte <= 8'($urandom);
                in_ch.end_mark  <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_mark  <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        byte_cnt++;
        if (!(e && seq_left == 0))
            counted_items++;
        decode_byte(b, e);
    endtask

    task automatic send_char(input int n, input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] v;
        v = cp & low_ones(seq_bits(n));
        if (n == 1) begin
            send_byte({1'b0, v[6:0]}, 1'b0);
        end else begin
            send_byte(lead_prefix(n) | 8'(v >> (6 * (n - 1))), 1'b0);
            for (int k = n - 2; k >= 0; k--)
                send_byte(8'h80 | 8'((v >> (6 * k)) & 31'h3F), 1'b0);
        end
    endtask

    // Lead byte of an n-byte sequence followed by only k continuation bytes
    task automatic send_open_seq(input int n, input int k);
        send_byte(lead_prefix(n) | 8'($urandom_range(0, (1 << (7 - n)) - 1)), 1'b0);
        repeat (k) send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
    endtask

    task automatic test_single_byte();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_multi_byte();
        send_char(2, 31'h80);
        send_char(2, 31'h7F);            // overlong two-byte form
        send_char(6, 31'h7FFFFFFF);
        send_char(6, 31'h03FFFFFF);      // largest overlong six-byte form
    endtask

    task automatic test_bad_lead();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);          // consumed, not decoded as ASCII
    endtask

    task automatic test_truncation();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hA5, 1'b1);          // end mark while idle
    endtask

    // Receiver holds off while the sender keeps pushing result-producing bytes
    task automatic test_hold_off();
        steady_sender = 1'b1;
        hold_request  = HOLD_OFF_LEN;
        repeat (40) send_char(1, 31'($urandom));
        repeat (10) send_char($urandom_range(2, 4), 31'($urandom));
        steady_sender = 1'b0;
    endtask

    task automatic test_random_stream(input int n_items);
        int sel;
        int n;
        int b_prev;
        logic [7:0] junk;
        logic [CP_W-1:0] v;
        n_items += counted_items;
        while (counted_items < n_items) begin
            sel = $urandom_range(0, 99);
            // occasional steady stretches with no sender gaps
            if ($urandom_range(0, 63) == 0)
                steady_sender = !steady_sender;
            if (sel < 70) begin
                n = $urandom_range(1, 6);
                b_prev = (n <= 2) ? 7 : seq_bits(n - 1);
                case ($urandom_range(0, 7))
                    0: v = low_ones(b_prev);
                    1: v = low_ones(b_prev) + 31'h1;
                    2: v = 31'($urandom) & low_ones(b_prev);
                    default: v = 31'($urandom);
                endcase
                send_char(n, v);
            end else if (sel < 80) begin
                n = $urandom_range(2, 6);
                send_open_seq(n, $urandom_range(0, n - 2));
                send_byte(8'($urandom), 1'b1);
            end else if (sel < 90) begin
                n = $urandom_range(2, 6);
                send_open_seq(n, $urandom_range(0, n - 2));
                junk = 8'($urandom);
                if (junk[7:6] == CONT_TAG)
                    junk[6] = 1'b1;
                send_byte(junk, 1'b0);
            end else begin
                send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
            end
        end
        steady_sender = 1'b0;
    endtask

    // Result receiver: random stall duty that changes now and then, plus the hold-off
    initial begin : receiver
        int hold_left;
        int stall_pct;
        int phase_left;
        hold_left  = 0;
        stall_pct  = 0;
        phase_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_char.code_point   = out_ch.code_point;
            got_char.decode_error = out_ch.decode_error;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected result, expected none, got code_point=%h decode_error=%b",
                         $time, got_char.code_point, got_char.decode_error);
                fail_cnt++;
            end else begin
                want_char = expected_chars.pop_front();
                checked_cnt++;
                if (got_char.code_point !== want_char.code_point) begin
                    $display("%0t: code_point mismatch, expected %h, got %h",
                             $time, want_char.code_point, got_char.code_point);
                    fail_cnt++;
                end
                if (got_char.decode_error !== want_char.decode_error) begin
                    $display("%0t: decode_error mismatch, expected %b, got %b",
                             $time, want_char.decode_error, got_char.decode_error);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_chars.size());
            $display("utf8_stream_decoder_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.end_mark  <= 1'b0;
        i_rst_n         <= 1'b0;
        open_seq('0, 3'd0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_byte();
        test_multi_byte();
        test_bad_lead();
        test_bad_continuation();
        test_truncation();
        test_hold_off();
        test_random_stream(RANDOM_ITEMS);

        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_cnt += expected_chars.size();

        $display("Sent %0d byte transactions: %0d characters and %0d error reports predicted,",
                 byte_cnt, char_cnt, err_cnt);
        $display("%0d results checked with %0d mismatches.", checked_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("utf8_stream_decoder_top test passed");
        else
            $display("utf8_stream_decoder_top test failed");
        $finish;
    end

endmodule
